// ===== hw/rtl/framed_payload_receiver_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef FRAMED_PAYLOAD_RECEIVER_DEFINES_SVH
`define FRAMED_PAYLOAD_RECEIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame receiver check failed");

// next-cycle implication, checked out of reset
`define FRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame receiver check failed");

`endif

// ===== hw/rtl/frp_pkg.sv =====
// Types and constants of the framed payload receiver.
package frp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned CHECK_W = 16;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND = 8'd3;

	typedef enum logic [9:0] {
		PH_HEAD0 = 10'b00_0000_0001,
		PH_HEAD1 = 10'b00_0000_0010,
		PH_ID    = 10'b00_0000_0100,
		PH_LEN   = 10'b00_0000_1000,
		PH_DATA  = 10'b00_0001_0000,
		PH_CHK0  = 10'b00_0010_0000,
		PH_CHK1  = 10'b00_0100_0000,
		PH_END0  = 10'b00_1000_0000,
		PH_END1  = 10'b01_0000_0000,
		PH_EMIT  = 10'b10_0000_0000
	} phase_t;

endpackage

// ===== hw/rtl/framed_payload_receiver.sv =====
// Framed payload receiver: length-prefixed frame parser with a payload buffer.
//
// Input stream s_axis: one received byte per item. Frames are two header
// bytes, an id byte, a length byte, the payload (length 0 still takes one
// byte), two check bytes and two end bytes. Header and end values are set
// through the cfg write port (cfg_ready is always high).
// Payload bytes go into a single-port buffer of MAX_PAYLOAD bytes; bytes
// beyond it are dropped and the run is marked truncated.
// While parsing, s_axis_tready is high and each offered byte is taken. On a good final
// end byte of a frame with nonzero length the block stops taking input and walks
// the buffer: one read, then one output load. The end byte moves the phase to emit,
// each read fills rd_data_s1 and its load fills the output register; a new read waits
// until the pending one is loaded. s_axis_tready stays low until the walk is done.
// Output stream m_axis: one item per payload byte with its index, the id,
// the raw check word and the truncated flag; tlast marks the final byte.
// A stalled m_axis holds the output register and the walk waits for it.
// Reset clears the parser to the header hunt and the control and config
// registers to zero; the buffer is not cleared, only entries written by the
// current frame are read.
`include "framed_payload_receiver_defines.svh"

module framed_payload_receiver #(
	parameter int unsigned MAX_PAYLOAD = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [frp_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] payload_byte, [13:8] byte_index, [21:14] frame_tag,
	// [37:22] check_word, [39:38] zero
	output logic [39:0]                     m_axis_tdata,
	output logic [0:0]                      m_axis_tuser,   // [0] truncated
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frp_pkg::BYTE_W-1:0]      cfg_data
);
	import frp_pkg::*;

	localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [BYTE_W-1:0]  MAX_B = BYTE_W'(MAX_PAYLOAD);
	localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_PAYLOAD);

	logic [BYTE_W-1:0] head_first_q, head_second_q, tail_first_q, tail_second_q;
	phase_t            phase_q;
	logic [BYTE_W-1:0] tag_q;
	logic [BYTE_W-1:0] declared_q;
	logic [BYTE_W-1:0] received_q;
	logic [CHECK_W-1:0] check_q;
	logic              trunc_q;
	logic [COUNT_W-1:0] emit_total_q;
	logic [COUNT_W-1:0] emit_cnt_q;

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
	logic [BYTE_W-1:0] rd_data_s1;
	logic              rd_pend_s1;
	logic [COUNT_W-1:0] idx_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [BYTE_W-1:0] out_tag_q;
	logic [CHECK_W-1:0] out_check_q;
	logic              out_trunc_q;
	logic              out_last_q;

	logic              in_fire;
	logic              out_fire;
	logic              issue;
	logic              wr_en;
	logic [BYTE_W-1:0] rx;
	logic [BYTE_W-1:0] received_next;
	logic              end_trunc;
	logic [COUNT_W-1:0] end_total;

	assign rx            = s_axis_tdata;
	assign s_axis_tready = (phase_q != PH_EMIT);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;
	assign cfg_ready     = 1'b1;

	assign received_next = (received_q != 8'hFF) ? received_q + 8'd1 : received_q;
	assign wr_en         = in_fire && (phase_q == PH_DATA) && (received_q < MAX_B);
	assign end_trunc     = declared_q > MAX_B;
	assign end_total     = end_trunc ? MAX_C : declared_q[COUNT_W-1:0];
	assign issue         = (phase_q == PH_EMIT) && (emit_cnt_q < emit_total_q)
		&& !rd_pend_s1 && (!out_valid_q || m_axis_tready);

	// payload buffer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[received_q[AW-1:0]] <= rx;
		end
		if (issue) begin
			rd_data_s1 <= mem[emit_cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_first_q  <= '0;
			head_second_q <= '0;
			tail_first_q  <= '0;
			tail_second_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HEAD_FIRST:  head_first_q  <= cfg_data;
				CFG_HEAD_SECOND: head_second_q <= cfg_data;
				CFG_TAIL_FIRST:  tail_first_q  <= cfg_data;
				CFG_TAIL_SECOND: tail_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEAD0;
			tag_q        <= '0;
			declared_q   <= '0;
			received_q   <= '0;
			check_q      <= '0;
			trunc_q      <= 1'b0;
			emit_total_q <= '0;
			emit_cnt_q   <= '0;
			rd_pend_s1   <= 1'b0;
			idx_s1       <= '0;
		end else begin
			rd_pend_s1 <= issue;
			if (issue) begin
				idx_s1     <= emit_cnt_q;
				emit_cnt_q <= emit_cnt_q + 7'd1;
			end
			unique case (phase_q)
				PH_HEAD0: begin
					if (in_fire && rx == head_first_q) phase_q <= PH_HEAD1;
				end
				PH_HEAD1: begin
					if (in_fire) phase_q <= (rx == head_second_q) ? PH_ID : PH_HEAD0;
				end
				PH_ID: begin
					if (in_fire) begin
						tag_q   <= rx;
						phase_q <= PH_LEN;
					end
				end
				PH_LEN: begin
					if (in_fire) begin
						declared_q <= rx;
						received_q <= '0;
						phase_q    <= PH_DATA;
					end
				end
				PH_DATA: begin
					if (in_fire) begin
						received_q <= received_next;
						if (received_next >= declared_q) phase_q <= PH_CHK0;
					end
				end
				PH_CHK0: begin
					if (in_fire) begin
						check_q[15:8] <= rx;
						phase_q       <= PH_CHK1;
					end
				end
				PH_CHK1: begin
					if (in_fire) begin
						check_q[7:0] <= rx;
						phase_q      <= PH_END0;
					end
				end
				PH_END0: begin
					if (in_fire) phase_q <= (rx == tail_first_q) ? PH_END1 : PH_HEAD0;
				end
				PH_END1: begin
					if (in_fire) begin
						trunc_q      <= end_trunc;
						emit_total_q <= end_total;
						emit_cnt_q   <= '0;
						phase_q      <= (rx == tail_second_q && end_total != '0)
							? PH_EMIT : PH_HEAD0;
					end
				end
				PH_EMIT: begin
					if (emit_cnt_q == emit_total_q && !rd_pend_s1) phase_q <= PH_HEAD0;
				end
				default: phase_q <= PH_HEAD0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_byte_q  <= rd_data_s1;
			out_index_q <= idx_s1[INDEX_W-1:0];
			out_tag_q   <= tag_q;
			out_check_q <= check_q;
			out_trunc_q <= trunc_q;
			out_last_q  <= (idx_s1 + 7'd1) == emit_total_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_check_q, out_tag_q, out_index_q, out_byte_q};
	assign m_axis_tuser  = out_trunc_q;
	assign m_axis_tlast  = out_last_q;

	`FRP_ASSERT_IMPL(a_slot_free, clk, arst_n, rd_pend_s1, !out_valid_q || m_axis_tready)
	`FRP_ASSERT_IMPL(a_emit_bound, clk, arst_n, 1'b1, emit_cnt_q <= emit_total_q)
	`FRP_ASSERT_IMPL(a_pend_in_emit, clk, arst_n, rd_pend_s1, phase_q == PH_EMIT)
	`FRP_ASSERT_NEXT(a_load_valid, clk, arst_n, rd_pend_s1, out_valid_q)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for framed_payload_receiver: byte frames in, payload runs out.
module testbench;
	import frp_pkg::*;

	localparam int PAYLOAD_CAP   = 64;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_BYTES   = 14;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

	typedef enum int {FRAME_OK, BAD_HEAD, BAD_TAIL_FIRST, BAD_TAIL_SECOND} frame_fault_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [5:0]  idx;
		logic [7:0]  tag;
		logic [15:0] chk;
		logic        trunc;
		logic        is_last;
	} payload_item_t;

	typedef struct {
		bit           reconfig;
		logic [31:0]  cfg;
		logic [7:0]   tag;
		logic [7:0]   len;
		logic [7:0]   seed;
		logic [15:0]  chk;
		frame_fault_t fault;
		int           n_typed;
	} frame_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [39:0]          m_axis_tdata;   // [7:0] payload, [13:8] index, [21:14] tag, [37:22] check
	logic [0:0]           m_axis_tuser;   // [0] truncated
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	framed_payload_receiver #(.MAX_PAYLOAD(PAYLOAD_CAP)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// register shadows and parser state
	logic [7:0]  head_first_r, head_second_r, tail_first_r, tail_second_r;
	phase_t      rx_phase;
	logic [7:0]  held_tag, held_len, rx_count;
	logic [15:0] held_check;
	logic [7:0]  payload_buf [PAYLOAD_CAP];

	payload_item_t pending_payload_q[$];
	payload_item_t got, want;
	int errors = 0, bytes_sent = 0, frames_sent = 0, items_checked = 0, trunc_seen = 0;
	int send_idle_pct = 0, recv_stall_pct = 0, cycle_count = 0;

	frame_row_t frame_table[12] = '{
		'{1'b0, 32'h00000000, 8'h5A, 8'd3,   8'h10, 16'h1234, FRAME_OK,        3},
		'{1'b1, 32'hAA550D0A, 8'h00, 8'd1,   8'h00, 16'h0000, FRAME_OK,        1},
		'{1'b0, 32'h0,        8'h01, 8'd0,   8'h77, 16'h0000, FRAME_OK,        0},
		'{1'b0, 32'h0,        8'hFF, 8'd64,  8'h80, 16'hFFFF, FRAME_OK,        64},
		'{1'b0, 32'h0,        8'h42, 8'd65,  8'h00, 16'hABCD, FRAME_OK,        64},
		'{1'b0, 32'h0,        8'h11, 8'd2,   8'h20, 16'h3344, BAD_HEAD,        -1},
		'{1'b0, 32'h0,        8'h12, 8'd2,   8'h30, 16'h5566, BAD_TAIL_FIRST,  0},
		'{1'b0, 32'h0,        8'h13, 8'd2,   8'h40, 16'h7788, BAD_TAIL_SECOND, 0},
		'{1'b0, 32'h0,        8'h14, 8'd5,   8'hC0, 16'h9ABC, FRAME_OK,        -1},
		'{1'b1, 32'hFFFFFFFF, 8'hFF, 8'd2,   8'hFF, 16'hFFFF, FRAME_OK,        2},
		'{1'b1, 32'h00FFFF00, 8'h00, 8'd1,   8'h00, 16'h0000, FRAME_OK,        -1},
		'{1'b0, 32'h0,        8'h7E, 8'd3,   8'hF0, 16'h0102, BAD_TAIL_FIRST,  -1}
	};

	task automatic parse_rx(input logic [7:0] b, input bit publish);
		bit trunc;
		int n;
		case (rx_phase)
		PH_HEAD0: if (b == head_first_r) rx_phase = PH_HEAD1;
		PH_HEAD1: begin
			if (b == head_second_r) rx_phase = PH_ID;
			else rx_phase = PH_HEAD0;
		end
		PH_ID: begin
			held_tag = b;
			rx_phase = PH_LEN;
		end
		PH_LEN: begin
			held_len = b;
			rx_count = '0;
			rx_phase = PH_DATA;
		end
		PH_DATA: begin
			if (rx_count < PAYLOAD_CAP) payload_buf[rx_count[5:0]] = b;
			if (rx_count != 8'd255) rx_count++;
			if (rx_count >= held_len) rx_phase = PH_CHK0;
		end
		PH_CHK0: begin
			held_check[15:8] = b;
			rx_phase = PH_CHK1;
		end
		PH_CHK1: begin
			held_check[7:0] = b;
			rx_phase = PH_END0;
		end
		PH_END0: begin
			if (b == tail_first_r) rx_phase = PH_END1;
			else rx_phase = PH_HEAD0;
		end
		PH_END1: begin
			if (b == tail_second_r && publish) begin
				trunc = held_len > PAYLOAD_CAP;
				n = trunc ? PAYLOAD_CAP : int'(held_len);
				for (int i = 0; i < n; i++)
					pending_payload_q.push_back('{payload_buf[i], 6'(i), held_tag, held_check,
						trunc, i == n - 1});
			end
			rx_phase = PH_HEAD0;
		end
		default: rx_phase = PH_HEAD0;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input bit publish);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		parse_rx(b, publish);
	endtask

	task automatic send_frame(input logic [7:0] tag, input logic [7:0] len, input logic [7:0] seed,
			input bit rand_fill, input logic [15:0] chk, input frame_fault_t fault,
			input bit publish);
		int n_data;
		n_data = (len == 0) ? 1 : int'(len);
		send_byte(head_first_r, publish);
		send_byte(fault == BAD_HEAD ? ~head_second_r : head_second_r, publish);
		send_byte(tag, publish);
		send_byte(len, publish);
		for (int i = 0; i < n_data; i++)
			send_byte(rand_fill ? 8'($urandom) : 8'(seed + i), publish);
		send_byte(chk[15:8], publish);
		send_byte(chk[7:0], publish);
		send_byte(fault == BAD_TAIL_FIRST ? ~tail_first_r : tail_first_r, publish);
		send_byte(fault == BAD_TAIL_SECOND ? ~tail_second_r : tail_second_r, publish);
		frames_sent++;
	endtask

	task automatic program_regs(input logic [31:0] v);
		logic [7:0]           vals [5];
		logic [CFG_IDX_W-1:0] idxs [5];
		vals = '{v[31:24], v[23:16], v[15:8], v[7:0], 8'($urandom)};
		idxs = '{CFG_HEAD_FIRST, CFG_HEAD_SECOND, CFG_TAIL_FIRST, CFG_TAIL_SECOND, CFG_IDX_UNUSED};
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		{head_first_r, head_second_r, tail_first_r, tail_second_r} = v;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_payload_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string what, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tdata[21:14],
				m_axis_tdata[37:22], m_axis_tuser[0], m_axis_tlast};
			if (pending_payload_q.size() == 0) begin
				$display("%0t: unexpected item, actual 0x%0h", $time, got);
				errors++;
			end else begin
				want = pending_payload_q.pop_front();
				check_field("payload_byte", want.data, got.data);
				check_field("byte_index", want.idx, got.idx);
				check_field("frame_tag", want.tag, got.tag);
				check_field("check_word", want.chk, got.chk);
				check_field("truncated", want.trunc, got.trunc);
				check_field("last_byte", want.is_last, got.is_last);
				items_checked++;
				if (got.trunc) trunc_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d items still expected", $time, pending_payload_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		frame_row_t  row;
		int          phase_bytes, pick, len_pick;
		logic [7:0]  len;
		logic [31:0] cfg_word;
		frame_fault_t fault;
		{head_first_r, head_second_r, tail_first_r, tail_second_r} = '0;
		rx_phase = PH_HEAD0;
		held_tag = '0;
		held_len = '0;
		rx_count = '0;
		held_check = '0;
		foreach (payload_buf[i]) payload_buf[i] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (frame_table[r]) begin
			row = frame_table[r];
			if (row.reconfig) begin
				settle();
				program_regs(row.cfg);
			end
			if (row.n_typed >= 0)
				for (int i = 0; i < row.n_typed; i++)
					pending_payload_q.push_back('{8'(row.seed + i), 6'(i), row.tag, row.chk,
						row.len > PAYLOAD_CAP, i == row.n_typed - 1});
			send_frame(row.tag, row.len, row.seed, 1'b0, row.chk, row.fault, row.n_typed < 0);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case (ph)
			1: cfg_word = 32'hFFFF0000;
			3: cfg_word = 32'h00FFFF00;
			default: cfg_word = $urandom;
			endcase
			program_regs(cfg_word);
			case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(99);
				len_pick = $urandom_range(99);
				if (len_pick < 4) len = 8'($urandom_range(65, 90));
				else if (len_pick < 12) len = 8'($urandom_range(13, 64));
				else len = 8'($urandom_range(0, 12));
				if (pick < 78) fault = FRAME_OK;
				else if (pick < 84) fault = BAD_HEAD;
				else if (pick < 89) fault = BAD_TAIL_FIRST;
				else fault = BAD_TAIL_SECOND;
				if (pick < 93) begin
					send_frame(8'($urandom), len, 8'h00, 1'b1, 16'($urandom), fault, 1'b1);
					phase_bytes += ((len == 0) ? 1 : int'(len)) + 8;
				end else begin
					repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b1);
				end
			end
		end

		settle();
		$display("Covered %0d bytes in %0d frames under %0d register settings;", bytes_sent,
			frames_sent, RANDOM_PHASES + 4);
		$display("%0d payload items checked, %0d of them from truncated runs.", items_checked,
			trunc_seen);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
